### rtl/crc32bs_pkg.sv
// Package for the CRC-32 byte stream unit: polynomial, widths, register
// indexes and the per-byte fold function. No dependencies.
`default_nettype none

package crc32bs_pkg;

  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned AddrWidth = 3;

  localparam logic [CrcWidth-1:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [CrcWidth-1:0] CrcOnes = 32'hFFFF_FFFF;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_START_VALUE = 1'b0,
    REG_WEAK_MODE   = 1'b1
  } reg_idx_e;

  typedef logic [CrcWidth-1:0] crc_t;

  // Fold one byte into the reflected CRC: eight shift and conditional XOR steps
  function automatic crc_t crc_fold_byte(crc_t crc_in, logic [ByteWidth-1:0] data);
    crc_t crc;
    crc = crc_in ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
    for (int i = 0; i < ByteWidth; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

### rtl/crc32bs_if.sv
// Channel interfaces of the CRC-32 byte stream unit: byte items in,
// checksum items out. Depends on crc32bs_pkg.
`default_nettype none

interface crc32bs_in_if
  import crc32bs_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] data_byte;
  logic                 first_byte;
  logic                 last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface crc32bs_out_if
  import crc32bs_pkg::*;
();
  logic valid;
  logic ready;
  crc_t crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

`default_nettype wire

### rtl/crc32_byte_stream_unit.sv
// CRC-32 (reflected 0xEDB88320) byte stream unit, top level.
// Depends on crc32bs_pkg and the channel interfaces in crc32bs_if.sv.
//
// Usage:
//   in_i  : one byte item per handshake (valid && ready), with first_byte
//           and last_byte marking the buffer bounds.
//   out_o : one checksum item for every byte item with last_byte set.
//   APB   : start_value at 0x0, weak_mode at 0x4; writes only while idle.
// Throughput: one byte item per cycle, sustained unless a last byte waits on a stalled out_o.
// Path: a last byte passes the input register, then the fold logic into the
//   output register, from which its checksum is shown on out_o.
// The fold is eight XOR steps between the input register and the CRC and
//   output registers.
// Stall: out_o holds its item while ready is low; a pending last byte then
//   waits in the input register, and in_i.ready drops only when both stages
//   are full. Non-last bytes never wait on out_o.
// Reset: clears both valid flags, the running CRC and the configuration registers.
`default_nettype none

module crc32_byte_stream_unit
  import crc32bs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  crc32bs_in_if.sink                in_i,
  crc32bs_out_if.source             out_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);

  // Configuration registers
  crc_t start_value_q;
  logic weak_mode_q;
  logic cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_value_q <= '0;
      weak_mode_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START_VALUE: start_value_q <= pwdata;
        REG_WEAK_MODE:   weak_mode_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_idx)
      REG_START_VALUE: prdata = start_value_q;
      REG_WEAK_MODE:   prdata = {31'd0, weak_mode_q};
      default:         prdata = '0;
    endcase
  end

  // Input register
  logic                 s1_vld_q;
  logic [ByteWidth-1:0] s1_byte_q;
  logic                 s1_first_q;
  logic                 s1_last_q;
  logic                 s1_adv;
  logic                 in_acc;

  // Output register and running CRC
  logic out_vld_q, out_vld_d;
  crc_t out_crc_q;
  crc_t run_crc_q;
  crc_t inv_mask;
  crc_t crc_seed;
  crc_t crc_next;

  // A non-last byte always retires; a last byte needs a free output slot
  assign s1_adv   = s1_vld_q && (!s1_last_q || !out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_adv;
  assign in_acc   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q  <= in_i.data_byte;
      s1_first_q <= in_i.first_byte;
      s1_last_q  <= in_i.last_byte;
    end
  end

  // Fold logic: seed from start value on a first byte, else from the running CRC
  assign inv_mask = weak_mode_q ? '0 : CrcOnes;
  assign crc_seed = s1_first_q ? (start_value_q ^ inv_mask) : run_crc_q;
  assign crc_next = crc_fold_byte(crc_seed, s1_byte_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_crc_q <= '0;
    end else if (s1_adv) begin
      run_crc_q <= crc_next;
    end
  end

  // Output valid: set by a retiring last byte, cleared when taken
  always_comb begin
    out_vld_d = out_vld_q && !out_o.ready;
    if (s1_adv && s1_last_q) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_crc_q <= crc_next ^ inv_mask;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.crc_value = out_crc_q;

endmodule

`default_nettype wire

### rtl/crc32bs_checker.sv
// Port-level checker for crc32_byte_stream_unit, bound to the top level.
// Depends on crc32bs_pkg.
`default_nettype none

module crc32bs_checker
  import crc32bs_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_last_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic pready_i
);

  // A pending result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  // A new result is only raised for an earlier accepted last byte
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2))
    else $error("output item without an accepted last byte");

  // With no result pending the input side never stalls
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // APB never waits, and reset clears the output
  a_cfg_ready: assert property (@(posedge clk_i)
    pready_i && (rst_ni || !out_valid_i))
    else $error("pready low or output valid in reset");

endmodule

bind crc32_byte_stream_unit crc32bs_checker u_crc32bs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_byte),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pready_i    (pready)
);

`default_nettype wire
